// ===== sv/ppm_pkg.sv =====
// Shared types and constants for the plain-text PPM encoder.
`timescale 1ns / 1ps
package ppm_pkg;

  // Item codes
  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_PIXEL  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // Separator test limit
  localparam logic [7:0] LINE_LIMIT = 8'd70;

  // Decimal converter geometry for 16-bit header numbers
  localparam int unsigned DecDigits = 5;
  localparam int unsigned DecIdxW   = 3;

  // ASCII characters
  localparam logic [7:0] ASCII_NL    = 8'h0A;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_TWO   = 8'h32;
  localparam logic [7:0] ASCII_THREE = 8'h33;
  localparam logic [7:0] ASCII_FIVE  = 8'h35;
  localparam logic [7:0] ASCII_P     = 8'h50;

  typedef struct packed {
    logic              mode;
    logic signed [15:0] red_level;
    logic signed [15:0] green_level;
    logic signed [15:0] blue_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_of_run;
  } out_item_t;

  // One color component as decimal digits (index 0 = ones)
  typedef struct packed {
    logic [2:0][3:0] digit;
    logic [1:0]      len;
  } lane_t;

  // Item waiting for the serializer
  typedef struct packed {
    logic            mode;
    lane_t [2:0]     lane;
  } slot_t;

  // Result of a 16-bit decimal conversion
  typedef struct packed {
    logic [DecDigits-1:0][3:0] digit;
    logic [DecIdxW-1:0]        len;
    logic                      done;
  } dec_t;

endpackage

// ===== sv/ppm_plain_text_encoder.sv =====
// Top level of the plain-text PPM (P3) encoder.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): mode 0 starts a frame
//   and emits the header "P3", width, height and "255"; mode 1 carries three
//   signed Q4.12 color levels that become decimal values 0..255.
//   Output channel (out_valid_o / out_stall_i / out_data_o): one ASCII byte per
//   transaction, last_of_run set on the final byte of each input item.
//   Configuration port (cfg_valid_i / cfg_ready_o): index 0 sets image width,
//   index 1 sets image height; always ready. Write only while idle.
// Path: a pixel's first byte passes through the slot, the sequencer state and
//   the output register; a header waits after "P3\n" for the 5-step decimal
//   conversion of width and height (one digit per cycle, both in parallel).
// Throughput: one byte per cycle from the output register while the receiver
//   does not stall; a pixel is 6 to 12 bytes, a header up to 19 and the wait.
//   The next item is held in a one-entry slot, so pixels follow with no gap.
// Reset: width and height return to 1, line length and column to 0, and all
//   channels are empty. A stalled receiver holds the output byte; the block
//   then stops after filling its slot and raises in_stall_o.
`timescale 1ns / 1ps
module ppm_plain_text_encoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ppm_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ppm_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ppm_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [15:0]                         cfg_data_i
);
  import ppm_pkg::*;

  logic [15:0] width_q;
  logic [15:0] height_q;
  logic        slot_valid_q;
  slot_t       slot_q;
  slot_t       slot_d;
  logic        in_accept;
  logic        load;
  logic        conv_start;
  dec_t        wid_dec;
  dec_t        hgt_dec;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 16'd1;
      height_q <= 16'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_IMAGE_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // Color lanes
  ppm_lane u_lane_red (
    .level_i (in_data_i.red_level),
    .lane_o  (slot_d.lane[0])
  );

  ppm_lane u_lane_green (
    .level_i (in_data_i.green_level),
    .lane_o  (slot_d.lane[1])
  );

  ppm_lane u_lane_blue (
    .level_i (in_data_i.blue_level),
    .lane_o  (slot_d.lane[2])
  );

  assign slot_d.mode = in_data_i.mode;

  // One-entry slot in front of the serializer
  assign in_stall_o = slot_valid_q && !load;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
    end else if (in_accept) begin
      slot_valid_q <= 1'b1;
    end else if (load) begin
      slot_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      slot_q <= slot_d;
    end
  end

  // Header number converters
  ppm_dec16 u_dec_wid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (conv_start),
    .value_i  (width_q),
    .result_o (wid_dec)
  );

  ppm_dec16 u_dec_hgt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (conv_start),
    .value_i  (height_q),
    .result_o (hgt_dec)
  );

  // Serializer and output register
  ppm_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slot_valid_i (slot_valid_q),
    .slot_i       (slot_q),
    .width_i      (width_q),
    .wid_dec_i    (wid_dec),
    .hgt_dec_i    (hgt_dec),
    .load_o       (load),
    .conv_start_o (conv_start),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

// ===== sv/ppm_lane.sv =====
// One color lane: Q4.12 level scaled to 0..255 and split into decimal digits.
`timescale 1ns / 1ps
module ppm_lane (
  input  logic signed [15:0] level_i,
  output ppm_pkg::lane_t     lane_o
);
  import ppm_pkg::*;

  logic signed [24:0] lvl_ext;
  logic signed [24:0] prod;
  logic [20:0]        rsum;
  logic [7:0]         val;
  logic [1:0]         hund;
  logic [7:0]         rem8;
  logic [6:0]         rem7;
  logic [14:0]        tens_prod;
  logic [3:0]         tens;
  logic [6:0]         ones7;

  // Scale by 255, round half up, clamp to 0..255
  always_comb begin
    lvl_ext = {{9{level_i[15]}}, level_i};
    prod    = (lvl_ext <<< 8) - lvl_ext;
    rsum    = prod[20:0] + 21'd2048;
    if (level_i > 16'sd4096) begin
      val = 8'd255;
    end else if (prod[24]) begin
      val = 8'd0;
    end else begin
      val = rsum[19:12];
    end
  end

  // Decimal split: hundreds by compare, tens by reciprocal multiply
  always_comb begin
    if (val >= 8'd200) begin
      hund = 2'd2;
      rem8 = val - 8'd200;
    end else if (val >= 8'd100) begin
      hund = 2'd1;
      rem8 = val - 8'd100;
    end else begin
      hund = 2'd0;
      rem8 = val;
    end
    rem7      = rem8[6:0];
    tens_prod = {8'b0, rem7} * 15'd205;
    tens      = tens_prod[14:11];
    ones7     = rem7 - {tens, 3'b0} - {2'b0, tens, 1'b0};
    lane_o.digit[0] = ones7[3:0];
    lane_o.digit[1] = tens;
    lane_o.digit[2] = {2'b0, hund};
    if (val >= 8'd100) begin
      lane_o.len = 2'd3;
    end else if (val >= 8'd10) begin
      lane_o.len = 2'd2;
    end else begin
      lane_o.len = 2'd1;
    end
  end

endmodule

// ===== sv/ppm_dec16.sv =====
// Iterative 16-bit binary to decimal converter, one digit per cycle.
`timescale 1ns / 1ps
module ppm_dec16 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [15:0]         value_i,
  output ppm_pkg::dec_t       result_o
);
  import ppm_pkg::*;

  logic                      busy_q;
  logic                      done_q;
  logic [DecIdxW-1:0]        step_q;
  logic [DecIdxW-1:0]        len_q;
  logic [15:0]               rem_q;
  logic [DecDigits-1:0][3:0] digit_q;

  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] diff;

  // Divide by ten through the reciprocal 52429 / 2^19
  always_comb begin
    prod = {16'b0, rem_q} * 32'd52429;
    quot = {3'b0, prod[31:19]};
    diff = rem_q - ((quot << 3) + (quot << 1));
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      len_q  <= DecIdxW'(1);
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
      len_q  <= DecIdxW'(1);
    end else if (busy_q) begin
      if (rem_q != 16'd0) begin
        len_q <= step_q + DecIdxW'(1);
      end
      if (step_q == DecIdxW'(DecDigits - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        step_q <= step_q + DecIdxW'(1);
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= value_i;
    end else if (busy_q) begin
      rem_q           <= quot;
      digit_q[step_q] <= diff[3:0];
    end
  end

  assign result_o.digit = digit_q;
  assign result_o.len   = len_q;
  assign result_o.done  = done_q;

endmodule

// ===== sv/ppm_merge.sv =====
// Merging stage: serializes header and pixel digits into the byte stream.
`timescale 1ns / 1ps
module ppm_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                slot_valid_i,
  input  ppm_pkg::slot_t      slot_i,
  input  logic [15:0]         width_i,
  input  ppm_pkg::dec_t       wid_dec_i,
  input  ppm_pkg::dec_t       hgt_dec_i,
  output logic                load_o,
  output logic                conv_start_o,
  output logic                out_valid_o,
  output ppm_pkg::out_item_t  out_data_o,
  input  logic                out_stall_i
);
  import ppm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HDR_PRE,
    S_HDR_WAIT,
    S_HDR_WID,
    S_HDR_SP,
    S_HDR_HGT,
    S_HDR_TAIL,
    S_PIX_DIG,
    S_PIX_SEP
  } state_e;

  state_e             state_q;
  logic [DecIdxW-1:0] cnt_q;
  logic [1:0]         comp_q;
  logic [6:0]         ll_q;
  logic [15:0]        col_q;
  logic               out_valid_q;
  out_item_t          out_q;
  slot_t              cur_q;

  logic       out_free;
  logic       can_emit;
  logic       emit;
  logic       last;
  logic [7:0] byte_val;
  logic [1:0] cur_len;
  logic [1:0] nxt_len;
  logic [6:0] ll_sum;
  logic [7:0] total;
  logic       col_end;
  logic       row_end;
  logic       use_space;

  // Separator decision for the current component
  always_comb begin
    cur_len = cur_q.lane[comp_q].len;
    unique case (comp_q)
      2'd0:    nxt_len = cur_q.lane[1].len;
      2'd1:    nxt_len = cur_q.lane[2].len;
      default: nxt_len = 2'd0;
    endcase
    ll_sum    = ll_q + {5'b0, cur_len};
    total     = {1'b0, ll_sum} + {6'b0, cur_len} + 8'd1 + {6'b0, nxt_len};
    col_end   = ({1'b0, col_q} + 17'd1) >= {1'b0, width_i};
    row_end   = (comp_q == 2'd2) && col_end;
    use_space = !row_end && (total <= LINE_LIMIT);
  end

  // Byte for the current state
  always_comb begin
    can_emit = 1'b0;
    last     = 1'b0;
    byte_val = ASCII_NL;
    unique case (state_q)
      S_IDLE, S_HDR_WAIT: begin
        can_emit = 1'b0;
      end
      S_HDR_PRE: begin
        can_emit = 1'b1;
        unique case (cnt_q)
          3'd0:    byte_val = ASCII_P;
          3'd1:    byte_val = ASCII_THREE;
          default: byte_val = ASCII_NL;
        endcase
      end
      S_HDR_WID: begin
        can_emit = 1'b1;
        byte_val = ASCII_ZERO + {4'b0, wid_dec_i.digit[cnt_q]};
      end
      S_HDR_SP: begin
        can_emit = 1'b1;
        byte_val = ASCII_SPACE;
      end
      S_HDR_HGT: begin
        can_emit = 1'b1;
        byte_val = ASCII_ZERO + {4'b0, hgt_dec_i.digit[cnt_q]};
      end
      S_HDR_TAIL: begin
        can_emit = 1'b1;
        last     = (cnt_q == 3'd4);
        unique case (cnt_q)
          3'd1:       byte_val = ASCII_TWO;
          3'd2, 3'd3: byte_val = ASCII_FIVE;
          default:    byte_val = ASCII_NL;
        endcase
      end
      S_PIX_DIG: begin
        can_emit = 1'b1;
        byte_val = ASCII_ZERO + {4'b0, cur_q.lane[comp_q].digit[cnt_q[1:0]]};
      end
      S_PIX_SEP: begin
        can_emit = 1'b1;
        last     = (comp_q == 2'd2);
        byte_val = use_space ? ASCII_SPACE : ASCII_NL;
      end
      default: begin
        can_emit = 1'b0;
      end
    endcase
  end

  assign out_free     = !out_valid_q || !out_stall_i;
  assign emit         = can_emit && out_free;
  assign load_o       = slot_valid_i && ((state_q == S_IDLE) || (emit && last));
  assign conv_start_o = load_o && (slot_i.mode == MODE_HEADER);

  // Sequencer state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      ll_q        <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          // holds until the slot fills; the load below starts the item
        end
        S_HDR_PRE: begin
          if (emit) begin
            if (cnt_q == 3'd2) begin
              state_q <= S_HDR_WAIT;
            end else begin
              cnt_q <= cnt_q + 3'd1;
            end
          end
        end
        S_HDR_WAIT: begin
          if (wid_dec_i.done) begin
            state_q <= S_HDR_WID;
            cnt_q   <= wid_dec_i.len - 3'd1;
          end
        end
        S_HDR_WID: begin
          if (emit) begin
            if (cnt_q == 3'd0) begin
              state_q <= S_HDR_SP;
            end else begin
              cnt_q <= cnt_q - 3'd1;
            end
          end
        end
        S_HDR_SP: begin
          if (emit) begin
            state_q <= S_HDR_HGT;
            cnt_q   <= hgt_dec_i.len - 3'd1;
          end
        end
        S_HDR_HGT: begin
          if (emit) begin
            if (cnt_q == 3'd0) begin
              state_q <= S_HDR_TAIL;
            end else begin
              cnt_q <= cnt_q - 3'd1;
            end
          end
        end
        S_HDR_TAIL: begin
          if (emit) begin
            if (cnt_q == 3'd4) begin
              if (!slot_valid_i) begin
                state_q <= S_IDLE;
              end
              ll_q  <= '0;
              col_q <= '0;
            end else begin
              cnt_q <= cnt_q + 3'd1;
            end
          end
        end
        S_PIX_DIG: begin
          if (emit) begin
            if (cnt_q == 3'd0) begin
              state_q <= S_PIX_SEP;
            end else begin
              cnt_q <= cnt_q - 3'd1;
            end
          end
        end
        S_PIX_SEP: begin
          if (emit) begin
            ll_q <= use_space ? (ll_sum + 7'd1) : 7'd0;
            if (comp_q == 2'd2) begin
              if (!slot_valid_i) begin
                state_q <= S_IDLE;
              end
              col_q <= row_end ? 16'd0 : (col_q + 16'd1);
            end else begin
              state_q <= S_PIX_DIG;
              comp_q  <= comp_q + 2'd1;
              cnt_q   <= {1'b0, nxt_len - 2'd1};
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // Next item takes over at the end of the current one
      if (load_o) begin
        unique case (slot_i.mode)
          MODE_HEADER: begin
            state_q <= S_HDR_PRE;
            cnt_q   <= '0;
          end
          MODE_PIXEL: begin
            state_q <= S_PIX_DIG;
            comp_q  <= 2'd0;
            cnt_q   <= {1'b0, slot_i.lane[0].len - 2'd1};
          end
          default: begin
            state_q <= S_IDLE;
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (load_o) begin
      cur_q <= slot_i;
    end
    if (emit) begin
      out_q.text_byte   <= byte_val;
      out_q.last_of_run <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
